>>> hw/rtl/vpf_pkg.sv
`timescale 1ns / 1ps

package vpf_pkg;

  // func codes carried in tuser
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  // register indexes on the config port
  localparam int          CFG_INDEX_W     = 2;
  localparam logic [1:0]  REG_STALL_TICKS = 2'd0;
  localparam logic [1:0]  REG_TORQUE_HOLD = 2'd1;
  localparam logic [1:0]  REG_STOP_DELAY  = 2'd2;

  // status bit positions
  localparam int BIT_STALL        = 7;
  localparam int BIT_TORQUE_OPEN  = 6;
  localparam int BIT_FULLY_OPEN   = 5;
  localparam int BIT_LIMIT_OPEN   = 4;
  localparam int BIT_STOP_DELAY   = 3;
  localparam int BIT_TORQUE_CLOSE = 2;
  localparam int BIT_FULLY_CLOSED = 1;
  localparam int BIT_LIMIT_CLOSE  = 0;

  // reset values of the registers
  localparam logic [7:0] STALL_TICKS_RST = 8'd50;
  localparam logic [7:0] TORQUE_HOLD_RST = 8'd20;
  localparam logic [7:0] STOP_DELAY_RST  = 8'd20;

  // q2.14 full scale and rounding offset
  localparam logic signed [15:0] Q_ONE     = 16'sd16384;
  localparam logic signed [23:0] PCT_SCALE = 24'sd100;
  localparam logic signed [23:0] PCT_HALF  = 24'sd8192;

  typedef struct packed {
    logic [7:0] stall_ticks;
    logic [7:0] torque_hold_ticks;
    logic [7:0] stop_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] last_percent;
    logic [7:0] stall_count;
    logic [7:0] open_torque_count;
    logic [7:0] close_torque_count;
    logic [7:0] stop_count;
  } state_t;

  function automatic logic [7:0] inc_sat(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

>>> hw/rtl/vpf_update.sv
`timescale 1ns / 1ps

module vpf_update (
  input  vpf_pkg::cfg_t        cfg,
  input  vpf_pkg::state_t      cur,
  input  logic                 func,
  input  logic signed [15:0]   opening,
  input  logic                 motor_moving,
  input  logic                 torque_open_pin,
  input  logic                 torque_close_pin,
  input  logic                 limit_open_pin,
  input  logic                 limit_close_pin,
  output vpf_pkg::state_t      nxt
);
  import vpf_pkg::*;

  logic signed [23:0] scaled;
  logic signed [23:0] rounded;
  logic [7:0]         pct;

  // rounded percent, negative gives zero, saturate to a byte
  assign scaled  = 24'(opening) * PCT_SCALE;
  assign rounded = scaled + PCT_HALF;
  assign pct     = rounded[23] ? 8'd0 :
                   (rounded[22:14] > 9'd255) ? 8'hFF : rounded[21:14];

  always_comb begin
    nxt = cur;
    if (func == FUNC_EVENT) begin
      nxt.flags[BIT_STOP_DELAY] = 1'b1;
    end else begin
      // stall
      if (motor_moving) begin
        if (pct == cur.last_percent) begin
          nxt.stall_count = inc_sat(cur.stall_count);
        end else begin
          nxt.stall_count      = 8'd0;
          nxt.flags[BIT_STALL] = 1'b0;
        end
        if (nxt.stall_count >= cfg.stall_ticks) begin
          nxt.flags[BIT_STALL] = 1'b1;
          nxt.stall_count      = cfg.stall_ticks;
        end
        nxt.last_percent = pct;
      end else begin
        nxt.stall_count      = 8'd0;
        nxt.flags[BIT_STALL] = 1'b0;
      end

      // open torque
      if (torque_open_pin) begin
        nxt.open_torque_count      = 8'd0;
        nxt.flags[BIT_TORQUE_OPEN] = 1'b1;
      end
      if (nxt.flags[BIT_TORQUE_OPEN]) begin
        nxt.open_torque_count = inc_sat(nxt.open_torque_count);
        if (nxt.open_torque_count >= cfg.torque_hold_ticks) begin
          nxt.flags[BIT_TORQUE_OPEN] = 1'b0;
          nxt.open_torque_count      = cfg.torque_hold_ticks;
        end
      end

      // close torque
      if (torque_close_pin) begin
        nxt.close_torque_count      = 8'd0;
        nxt.flags[BIT_TORQUE_CLOSE] = 1'b1;
      end
      if (nxt.flags[BIT_TORQUE_CLOSE]) begin
        nxt.close_torque_count = inc_sat(nxt.close_torque_count);
        if (nxt.close_torque_count >= cfg.torque_hold_ticks) begin
          nxt.flags[BIT_TORQUE_CLOSE] = 1'b0;
          nxt.close_torque_count      = cfg.torque_hold_ticks;
        end
      end

      nxt.flags[BIT_LIMIT_OPEN]  = limit_open_pin;
      nxt.flags[BIT_LIMIT_CLOSE] = limit_close_pin;

      // end positions, the other end flag is left alone
      if (opening <= 16'sd0) begin
        nxt.flags[BIT_FULLY_CLOSED] = 1'b1;
      end else if (opening >= Q_ONE) begin
        nxt.flags[BIT_FULLY_OPEN] = 1'b1;
      end else begin
        nxt.flags[BIT_FULLY_CLOSED] = 1'b0;
        nxt.flags[BIT_FULLY_OPEN]   = 1'b0;
      end

      // stop delay
      if (nxt.flags[BIT_STOP_DELAY]) begin
        nxt.stop_count = inc_sat(cur.stop_count);
        if (nxt.stop_count >= cfg.stop_delay_ticks) begin
          nxt.flags[BIT_STOP_DELAY] = 1'b0;
          nxt.stop_count            = 8'd0;
        end
      end else begin
        nxt.stop_count = 8'd0;
      end
    end
  end

endmodule

>>> hw/rtl/valve_protection_flags_top.sv
`timescale 1ns / 1ps

// Valve actuator protection status. Each input word is either a periodic
// tick (tuser 0) that carries the Q2.14 valve opening, the motor-moving bit
// and four switch pins, or a motor-stopped event (tuser 1) that sets the
// stop-delay flag. Every input word yields exactly one output word holding
// the status byte after the update: bit 7 stall, 6 torque open, 5 fully
// open, 4 limit open, 3 stop delay, 2 torque close, 1 fully closed,
// 0 limit close. The block takes one word per cycle while the output is not
// stalled; a word passes an input register, the combinational flag logic
// and an output register. The whole flag update for a word settles
// combinationally, and the state registers load on the same edge the word
// moves to the output, which lets the next word follow at once. The three
// hold/count registers are written through the config port; the user must
// write them only while the block is idle, which the block does not
// enforce. Index 3 is ignored.

module valve_protection_flags_top (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_we,
  input  logic [vpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // opening[15:0], motor_moving[16], torque_open_pin[17],
  // torque_close_pin[18], limit_open_pin[19], limit_close_pin[20], zero pad
  input  logic [23:0]                     s_tdata,
  // func[0]
  input  logic                            s_tuser,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[7:0]
  output logic [7:0]                      m_tdata
);
  import vpf_pkg::*;

  cfg_t        cfg;
  state_t      state;
  state_t      state_next;

  // input register
  logic        in_valid;
  logic [20:0] in_data;
  logic        in_func;

  // stage moves when the output register is empty or being drained
  logic        advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_ticks       <= STALL_TICKS_RST;
      cfg.torque_hold_ticks <= TORQUE_HOLD_RST;
      cfg.stop_delay_ticks  <= STOP_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STALL_TICKS: cfg.stall_ticks       <= cfg_data;
        REG_TORQUE_HOLD: cfg.torque_hold_ticks <= cfg_data;
        REG_STOP_DELAY:  cfg.stop_delay_ticks  <= cfg_data;
        default: ;  // unused index
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata[20:0];
      in_func <= s_tuser;
    end
  end

  vpf_update u_update (
    .cfg              (cfg),
    .cur              (state),
    .func             (in_func),
    .opening          (in_data[15:0]),
    .motor_moving     (in_data[16]),
    .torque_open_pin  (in_data[17]),
    .torque_close_pin (in_data[18]),
    .limit_open_pin   (in_data[19]),
    .limit_close_pin  (in_data[20]),
    .nxt              (state_next)
  );

  // flag state loads together with the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= state_next.flags;
    end
  end

`ifndef SYNTHESIS
  // state only changes when a word moves through the update stage
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("flag state changed without an advancing word");

  // a stop count only runs while the stop-delay flag is up
  a_stop_count: assert property (@(posedge clk) disable iff (rst)
    state.stop_count != 8'd0 |-> state.flags[BIT_STOP_DELAY])
    else $error("stop count nonzero with stop-delay flag clear");

  // input backpressure only when both registers hold a word
  a_tready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // a new output word always comes from the input register
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("output word without an input word");
`endif

endmodule

>>> tb/tb_valve_protection_flags_top.sv
`timescale 1ns / 1ps

// self-checking bench for the valve protection status block
module tb_valve_protection_flags_top;
  import vpf_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  // index past the last register, the block must ignore it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_STALL_TICKS;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;
  logic        s_tuser = FUNC_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  // idle percentages of the sender and of the receiver for the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // status bytes still owed by the block, oldest first
  logic [7:0] status_due[$];

  // our own copy of the hold and count limits
  logic [7:0] stall_lim = STALL_TICKS_RST;
  logic [7:0] hold_lim = TORQUE_HOLD_RST;
  logic [7:0] stop_lim = STOP_DELAY_RST;

  // our own copy of the protection state
  logic [7:0] prot_flags = 8'd0;
  logic [7:0] last_pct = 8'd0;
  logic [7:0] stall_cnt = 8'd0;
  logic [7:0] open_hold_cnt = 8'd0;
  logic [7:0] close_hold_cnt = 8'd0;
  logic [7:0] stop_cnt = 8'd0;

  // directed word: pins holds limit_close, limit_open, torque_close,
  // torque_open, moving from msb down, i.e. tdata[20:16]
  typedef struct packed {
    logic        fn;
    logic [15:0] opening;
    logic [4:0]  pins;
    logic        known;
    logic [7:0]  status;
  } probe_t;

  probe_t probes [21] = '{
    // end positions from reset, nothing moving, no pins
    '{FUNC_TICK,  16'h0000, 5'b00000, 1'b1, 8'h02},
    // largest opening: fully open joins the still-set fully closed
    '{FUNC_TICK,  16'h7FFF, 5'b00000, 1'b1, 8'h22},
    // half open clears both end flags
    '{FUNC_TICK,  16'h2000, 5'b00000, 1'b1, 8'h00},
    // exactly full scale
    '{FUNC_TICK,  16'h4000, 5'b00000, 1'b1, 8'h20},
    // one below full scale
    '{FUNC_TICK,  16'h3FFF, 5'b00000, 1'b1, 8'h00},
    // slightly negative opening counts as closed
    '{FUNC_TICK,  16'hFFFF, 5'b00000, 1'b1, 8'h02},
    // most negative opening, every pin and moving
    '{FUNC_TICK,  16'h8000, 5'b11111, 1'b0, 8'h00},
    // event ignores opening and pins
    '{FUNC_EVENT, 16'h7FFF, 5'b11111, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h0001, 5'b00001, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h0001, 5'b00001, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h4000, 5'b01001, 1'b0, 8'h00},
    '{FUNC_EVENT, 16'h0000, 5'b00000, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h2000, 5'b00100, 1'b0, 8'h00},
    // steady position while moving walks the stall count
    '{FUNC_TICK,  16'h2000, 5'b00001, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h2000, 5'b00001, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h2000, 5'b00001, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h2000, 5'b00001, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h2000, 5'b00001, 1'b0, 8'h00},
    '{FUNC_EVENT, 16'h8000, 5'b11110, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h4001, 5'b10000, 1'b0, 8'h00},
    '{FUNC_TICK,  16'h0000, 5'b00010, 1'b0, 8'h00}
  };

  valve_protection_flags_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // opening[15:0], moving[16], torque open/close[18:17],
                            // limit open/close[20:19], zero pad
    .s_tuser   (s_tuser),   // func[0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)    // status[7:0]
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // counter increment that sticks at the top
  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

  // pin retriggers the hold, then the hold runs out after hold_lim ticks
  function automatic void torque_step(input logic pin, input int b, inout logic [7:0] cnt);
    if (pin) begin
      cnt = 8'd0;
      prot_flags[b] = 1'b1;
    end
    if (prot_flags[b]) begin
      cnt = bump(cnt);
      if (cnt >= hold_lim) begin
        prot_flags[b] = 1'b0;
        cnt = hold_lim;
      end
    end
  endfunction

  // advance the protection state by one word, return the new status byte
  function automatic logic [7:0] update_flags(input logic fn, input logic [23:0] word);
    logic signed [15:0] q;
    int x;
    logic [7:0] pct;
    q = word[15:0];
    if (fn == FUNC_EVENT) begin
      prot_flags[BIT_STOP_DELAY] = 1'b1;
    end else begin
      // rounded percent of the q2.14 opening, clipped to a byte
      x = int'(q) * 100 + 8192;
      if (x < 0) pct = 8'd0;
      else if (x / int'(Q_ONE) > 255) pct = 8'd255;
      else pct = 8'(x / int'(Q_ONE));

      // stall: same percent while moving
      if (word[16]) begin
        if (pct == last_pct) begin
          stall_cnt = bump(stall_cnt);
        end else begin
          stall_cnt = 8'd0;
          prot_flags[BIT_STALL] = 1'b0;
        end
        if (stall_cnt >= stall_lim) begin
          prot_flags[BIT_STALL] = 1'b1;
          stall_cnt = stall_lim;
        end
        last_pct = pct;
      end else begin
        stall_cnt = 8'd0;
        prot_flags[BIT_STALL] = 1'b0;
      end

      torque_step(word[17], BIT_TORQUE_OPEN, open_hold_cnt);
      torque_step(word[18], BIT_TORQUE_CLOSE, close_hold_cnt);

      prot_flags[BIT_LIMIT_OPEN] = word[19];
      prot_flags[BIT_LIMIT_CLOSE] = word[20];

      // the opposite end flag is left alone at either end
      if (q <= 0) begin
        prot_flags[BIT_FULLY_CLOSED] = 1'b1;
      end else if (q >= Q_ONE) begin
        prot_flags[BIT_FULLY_OPEN] = 1'b1;
      end else begin
        prot_flags[BIT_FULLY_CLOSED] = 1'b0;
        prot_flags[BIT_FULLY_OPEN] = 1'b0;
      end

      if (prot_flags[BIT_STOP_DELAY]) begin
        stop_cnt = bump(stop_cnt);
        if (stop_cnt >= stop_lim) begin
          prot_flags[BIT_STOP_DELAY] = 1'b0;
          stop_cnt = 8'd0;
        end
      end else begin
        stop_cnt = 8'd0;
      end
    end
    return prot_flags;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: %s: got %02h, want %02h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // offer one word, optionally after a random gap; returns on the accepting edge
  task automatic send_word(input logic fn, input logic [23:0] word, input bit known,
                           input logic [7:0] typed);
    logic [7:0] model_status;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= fn;
    do @(posedge clk); while (!s_tready);
    model_status = update_flags(fn, word);
    status_due.push_back(known ? typed : model_status);
  endtask

  // stop sending and let every owed status byte come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
    // margin past the input and output registers
    repeat (4) @(posedge clk);
  endtask

  // back-to-back register writes, only while the block is idle
  task automatic load_regs(input logic [7:0] s, input logic [7:0] h, input logic [7:0] d,
                           input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= REG_STALL_TICKS;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_TORQUE_HOLD;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_STOP_DELAY;
    cfg_data <= d;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data <= 8'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    stall_lim = s;
    hold_lim = h;
    stop_lim = d;
  endtask

  // random phase: runs of held opening and moving bit with sparse pin pulses
  // and stop events, mixed with fully random noise words
  task automatic run_phase(input int n, input int max_run, input int noise_pct,
                           input bit pause_mid);
    int i;
    int run_left;
    logic signed [15:0] hold_q;
    logic hold_mv;
    logic signed [15:0] q;
    logic [4:0] pins;
    logic fn;
    logic [23:0] word;
    run_left = 0;
    hold_q = 16'sd0;
    hold_mv = 1'b1;
    for (i = 0; i < n; i++) begin
      // sender holds off until the block has emptied
      if (pause_mid && i == n / 2) wait_drained();
      if ($urandom_range(99) < noise_pct) begin
        word = 24'($urandom);
        word[23:21] = 3'b000;
        fn = 1'($urandom_range(1));
        send_word(fn, word, 1'b0, 8'h00);
      end else begin
        if (run_left == 0) begin
          // a run that starts on the first word of a phase is the longest and always moving
          run_left = (i == 0) ? max_run : $urandom_range(1, max_run);
          hold_mv = (i == 0) || ($urandom_range(99) < 75);
          case ($urandom_range(7))
            0: hold_q = 16'sd0;
            1: hold_q = Q_ONE;
            2: hold_q = Q_ONE - 16'sd1;
            3: hold_q = 16'sh7FFF;
            4: hold_q = 16'sh8000;
            5: hold_q = -16'sd1;
            default: hold_q = 16'($urandom_range(0, 16384));
          endcase
        end
        run_left--;
        q = hold_q;
        // small wobble, sometimes crosses a percent step
        if ($urandom_range(99) < noise_pct) q = hold_q + 16'($urandom_range(0, 80)) - 16'sd40;
        pins[0] = hold_mv;
        pins[1] = ($urandom_range(99) < 5);
        pins[2] = ($urandom_range(99) < 5);
        pins[3] = ($urandom_range(99) < 30);
        pins[4] = ($urandom_range(99) < 30);
        fn = ($urandom_range(99) < 5) ? FUNC_EVENT : FUNC_TICK;
        send_word(fn, {3'b000, pins, q}, 1'b0, 8'h00);
      end
    end
  endtask

  // receiver backpressure
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // compare every accepted status word with the oldest one owed
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0) flag_mismatch("status word with none owed", m_tdata, 8'h00);
      else if (m_tdata !== status_due[0]) begin
        flag_mismatch("status", m_tdata, status_due[0]);
        void'(status_due.pop_front());
      end else begin
        void'(status_due.pop_front());
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // synchronous reset
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset limits, no idling
    foreach (probes[k])
      send_word(probes[k].fn, {3'b000, probes[k].pins, probes[k].opening},
                probes[k].known, probes[k].status);
    wait_drained();

    // short holds, mid-phase pause, no idling
    load_regs(8'd3, 8'd2, 8'd4, 1'b0);
    run_phase(300, 12, 8, 1'b1);
    wait_drained();

    // lowest nonzero limits, sender mostly idle
    send_idle_pct = 82;
    load_regs(8'd1, 8'd1, 8'd1, 1'b0);
    run_phase(250, 6, 10, 1'b0);
    wait_drained();

    // top limits with a clean run long enough to saturate the stall count,
    // receiver mostly stalled
    send_idle_pct = 0;
    recv_stall_pct = 82;
    load_regs(8'd255, 8'd255, 8'd255, 1'b0);
    run_phase(400, 300, 0, 1'b0);
    wait_drained();

    // zero limits, plus a write to the unused index, light idling both sides
    send_idle_pct = 10;
    recv_stall_pct = 10;
    load_regs(8'd0, 8'd0, 8'd0, 1'b1);
    run_phase(200, 8, 15, 1'b0);
    wait_drained();

    // random moderate limits, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_regs(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
              8'($urandom_range(1, 40)), 1'b0);
    run_phase(150, 60, 8, 1'b0);
    wait_drained();

    repeat (8) @(posedge clk);
    if (status_due.size() != 0)
      flag_mismatch("status words never delivered", 8'h00, 8'(status_due.size()));
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/vpf_pkg.sv
hw/rtl/vpf_update.sv
hw/rtl/valve_protection_flags_top.sv
tb/tb_valve_protection_flags_top.sv
